/* hw/rtl/tcpu_pkg.sv */
// Shared types and constants for the tiny CPU instruction step block.
// No dependencies.
package tcpu_pkg;

  localparam int MemBytes   = 4096;
  localparam int AddrW      = 12;
  localparam logic [11:0] StackStart = 12'd3840;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_PORT = 2'd2;

  localparam logic [6:0] OP_HLT  = 7'h00;
  localparam logic [6:0] OP_LDR  = 7'h01;
  localparam logic [6:0] OP_LDM  = 7'h02;
  localparam logic [6:0] OP_STI  = 7'h03;
  localparam logic [6:0] OP_STR  = 7'h04;
  localparam logic [6:0] OP_ADD  = 7'h05;
  localparam logic [6:0] OP_SUB  = 7'h06;
  localparam logic [6:0] OP_CMP  = 7'h07;
  localparam logic [6:0] OP_JZ   = 7'h08;
  localparam logic [6:0] OP_JN   = 7'h09;
  localparam logic [6:0] OP_JC   = 7'h0A;
  localparam logic [6:0] OP_JNC  = 7'h0B;
  localparam logic [6:0] OP_JBE  = 7'h0C;
  localparam logic [6:0] OP_JA   = 7'h0D;
  localparam logic [6:0] OP_JMP  = 7'h0E;
  localparam logic [6:0] OP_JNZ  = 7'h0F;
  localparam logic [6:0] OP_JNN  = 7'h10;
  localparam logic [6:0] OP_PUSH = 7'h11;
  localparam logic [6:0] OP_POP  = 7'h12;
  localparam logic [6:0] OP_CALL = 7'h13;
  localparam logic [6:0] OP_RET  = 7'h14;
  localparam logic [6:0] OP_IN   = 7'h15;
  localparam logic [6:0] OP_OUT  = 7'h16;

  localparam logic [2:0] FLAG_Z = 3'b001;
  localparam logic [2:0] FLAG_C = 3'b010;
  localparam logic [2:0] FLAG_N = 3'b100;

  typedef struct packed {
    logic        we;
    logic [11:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

endpackage

/* hw/rtl/tcpu_ram.sv */
// Byte-wide 4 KB RAM, one port, registered read data.
// Depends on tcpu_pkg.
module tcpu_ram (
  input  logic              clk,
  input  tcpu_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  import tcpu_pkg::*;

  logic [7:0] mem [MemBytes];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

/* hw/rtl/tcpu_alu.sv */
// 9-bit add/subtract unit with flag generation, shared by ADD, SUB and CMP.
// Depends on tcpu_pkg.
module tcpu_alu (
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic       sub,
  output logic [7:0] result,
  output logic [2:0] flags
);
  import tcpu_pkg::*;

  logic [8:0] sum;
  logic       neg;

  always_comb begin
    sum = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
    neg = sub && (a < b);
    result = sum[7:0];
    if (sum == 9'd0) begin
      flags = FLAG_Z;
    end else if (neg) begin
      flags = FLAG_N;
    end else if (sum[8]) begin
      flags = FLAG_C;
    end else begin
      flags = 3'b000;
    end
  end

endmodule

/* hw/rtl/tiny_cpu_instruction_step.sv */
// Tiny 8-bit CPU, one transaction per load, step or port-data item.
// Path, input to result transaction: load, port data and ignored items go straight to the
// output state; a step reads the three instruction bytes (byte 2 twice), then up to two RAM accesses.
// One item at a time; s_tready is low until the result is taken.
// Reset: rst (synchronous) clears registers, PC, SP, flags and wait state; RAM holds.
module tiny_cpu_instruction_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic [31:0] s_tdata,   // load_address[11:0], load_data[19:12],
                                 // port_data[27:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // next_pc[11:0], flag_bits[14:12], halted[15],
                                 // fault[16], port_write[17], port_read[18],
                                 // port_number[26:19], port_value[34:27]
);
  import tcpu_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_F0   = 4'd1;
  localparam logic [3:0] S_F1   = 4'd2;
  localparam logic [3:0] S_F2   = 4'd3;
  localparam logic [3:0] S_EXE  = 4'd4;
  localparam logic [3:0] S_MEM1 = 4'd5;
  localparam logic [3:0] S_MEM2 = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]  state;
  logic [7:0]  regs [4];
  logic [11:0] pc;
  logic [7:0]  sp;
  logic [2:0]  flags;
  logic        stopped, waiting;
  logic [1:0]  in_dest;
  logic [7:0]  b0, b1;
  logic        fault, pw, pr;
  logic [7:0]  pnum, pval, hi;
  mem_req_t    req;
  logic [7:0]  rdata;

  logic [1:0]  mode;
  logic [6:0]  op;
  logic        imm;
  logic [1:0]  d, s;
  logic [11:0] addr;
  logic [7:0]  rd, rs, alu_res;
  logic [2:0]  alu_flags;
  logic        take;

  tcpu_ram u_ram (.clk(clk), .req(req), .rdata(rdata));
  tcpu_alu u_alu (.a(rd), .b(rs), .sub(op != OP_ADD), .result(alu_res),
                  .flags(alu_flags));

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign mode = s_tuser;
  assign op   = b0[6:0];
  assign imm  = b0[7];
  assign d    = b1[7:6];
  assign s    = b1[5:4];
  assign addr = {b1[3:0], rdata};
  assign rd   = regs[d];
  assign rs   = regs[s];
  assign m_tdata = {5'd0, pval, pnum, pr, pw, fault, stopped, flags, pc};

  always_comb begin
    unique case (op)
      OP_JZ:   take = flags[0];
      OP_JN:   take = flags[2];
      OP_JC:   take = flags[1];
      OP_JNC:  take = !flags[1];
      OP_JBE:  take = flags[1] || flags[0];
      OP_JA:   take = !(flags[1] || flags[0]);
      OP_JMP:  take = 1'b1;
      OP_JNZ:  take = !flags[0];
      OP_JNN:  take = !flags[2];
      OP_CALL: take = 1'b1;
      default: take = 1'b0;
    endcase
  end

  // RAM address per state; the exec state may issue the first memory access
  always_comb begin
    req = '{we: 1'b0, addr: pc, wdata: 8'd0};
    unique case (state)
      S_IDLE: begin
        req.addr  = (mode == MODE_LOAD) ? s_tdata[11:0] : pc;
        req.wdata = s_tdata[19:12];
        req.we    = s_tvalid && (mode == MODE_LOAD);
      end
      S_F0: req.addr = pc + 12'd1;
      S_F1: req.addr = pc + 12'd2;
      // read byte 2 again so it is on rdata during exec
      S_F2: req.addr = pc + 12'd2;
      S_EXE: begin
        unique case (op)
          OP_LDM:  req.addr = imm ? addr : {4'd0, rs};
          OP_STI:  begin req.addr = {4'd0, rd}; req.wdata = rdata; req.we = imm; end
          OP_STR:  begin
            req.addr = imm ? addr : {4'd0, rd}; req.wdata = rs; req.we = 1'b1;
          end
          OP_PUSH: begin
            req.addr = StackStart + {4'd0, sp}; req.wdata = imm ? rdata : rd;
            req.we = 1'b1;
          end
          OP_POP, OP_RET: req.addr = StackStart + {4'd0, sp - 8'd1};
          OP_CALL: begin
            // return address is the PC past this instruction
            req.addr = StackStart + {4'd0, sp}; req.wdata = pc[7:0] + 8'd3;
            req.we = 1'b1;
          end
          default: req.addr = pc;
        endcase
      end
      S_MEM1: begin
        if (op == OP_CALL) begin
          req.addr = StackStart + {4'd0, sp}; req.wdata = {4'd0, hi[3:0]};
          req.we = 1'b1;
        end else begin
          req.addr = StackStart + {4'd0, sp - 8'd1};
        end
      end
      default: req.addr = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 4; i++) regs[i] <= 8'd0;
      pc <= '0; sp <= '0; flags <= '0;
      stopped <= 1'b0; waiting <= 1'b0; in_dest <= '0;
      fault <= 1'b0; pw <= 1'b0; pr <= 1'b0; pnum <= '0; pval <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          fault <= 1'b0; pw <= 1'b0; pr <= 1'b0; pnum <= '0; pval <= '0;
          state <= S_OUT;
          if (mode == MODE_PORT && waiting) begin
            regs[in_dest] <= s_tdata[27:20];
            waiting <= 1'b0;
          end else if (mode == MODE_STEP && !stopped && !waiting) begin
            state <= S_F0;
          end
        end
        S_F0: begin b0 <= rdata; state <= S_F1; end
        S_F1: begin b1 <= rdata; state <= S_F2; end
        S_F2: state <= S_EXE;
        S_EXE: begin
          // rdata holds byte 2 here
          pc <= take ? addr : pc + 12'd3;
          hi <= {4'd0, pc[11:8] + ((pc[7:0] > 8'd252) ? 4'd1 : 4'd0)};
          state <= S_OUT;
          unique case (op)
            OP_HLT:  stopped <= 1'b1;
            OP_LDR:  regs[d] <= imm ? rdata : rs;
            OP_LDM:  state <= S_MEM1;
            OP_STI:  if (!imm) begin stopped <= 1'b1; fault <= 1'b1; end
            OP_STR, OP_JZ, OP_JN, OP_JC, OP_JNC, OP_JBE, OP_JA, OP_JMP, OP_JNZ,
            OP_JNN: ;
            OP_ADD, OP_SUB: begin flags <= alu_flags; regs[d] <= alu_res; end
            OP_CMP:  flags <= alu_flags;
            OP_PUSH: sp <= sp + 8'd1;
            OP_POP:  begin sp <= sp - 8'd1; state <= S_MEM1; end
            OP_RET:  begin sp <= sp - 8'd1; state <= S_MEM1; end
            OP_CALL: begin sp <= sp + 8'd1; state <= S_MEM1; end
            OP_IN: begin
              pnum <= imm ? rdata : rs; pr <= 1'b1;
              waiting <= 1'b1; in_dest <= d;
            end
            OP_OUT: begin pnum <= imm ? rdata : rd; pval <= rs; pw <= 1'b1; end
            default: begin stopped <= 1'b1; fault <= 1'b1; end
          endcase
        end
        S_MEM1: begin
          state <= S_OUT;
          unique case (op)
            OP_LDM, OP_POP: regs[d] <= rdata;
            OP_CALL: sp <= sp + 8'd1;
            default: begin hi <= rdata; sp <= sp - 8'd1; state <= S_MEM2; end
          endcase
        end
        S_MEM2: begin
          pc <= {hi[3:0], rdata};
          state <= S_OUT;
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
